/* rtl/numeric_literal_scanner_defines.svh */
// ----------------------------------------------------------------------------
// Numeric literal scanner: assertion macros
// Concurrent assertion wrappers that sample on clk and may be compiled out.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_SCANNER_DEFINES_SVH
`define NUMERIC_LITERAL_SCANNER_DEFINES_SVH

`ifndef SYNTH
// Checked only outside reset.
`define NLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("numeric literal scanner check failed");
// Checked on every edge, reset included.
`define NLS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("numeric literal scanner reset check failed");
`else
`define NLS_ASSERT(lbl, prop)
`define NLS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/nls_pkg.sv */
// ----------------------------------------------------------------------------
// Numeric literal scanner package
// Scanner phases, number bases, result kinds and character classes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nls_pkg;

  // Scanner phase.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ZERO   = 3'd1,
    PH_MAIN   = 3'd2,
    PH_POINT  = 3'd3,
    PH_EXP    = 3'd4,
    PH_SUFFIX = 3'd5,
    PH_BAD    = 3'd6
  } phase_t;

  // Number base of the literal.
  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2,
    BASE_OCT = 2'd3
  } base_t;

  // Result kinds; integer kinds are KIND_DEC_INT + 3 * base + suffix.
  localparam logic [3:0] KIND_ILLEGAL = 4'd0;
  localparam logic [3:0] KIND_FLOAT   = 4'd1;
  localparam logic [3:0] KIND_DEC_INT = 4'd2;

  // Integer suffix.
  localparam logic [1:0] SFX_NONE = 2'd0;
  localparam logic [1:0] SFX_U    = 2'd1;
  localparam logic [1:0] SFX_UZ   = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_UU    = 8'h55;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  function automatic logic is_dec_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // True when c is a digit of the given base.
  function automatic logic is_base_digit(base_t b, logic [7:0] c);
    logic res;
    unique case (b)
      BASE_HEX: res = is_dec_digit(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
                      ((c >= CH_UA) && (c <= CH_UF));
      BASE_BIN: res = (c == CH_0) || (c == CH_1);
      BASE_OCT: res = (c >= CH_0) && (c <= CH_7);
      BASE_DEC: res = is_dec_digit(c);
    endcase
    return res;
  endfunction

  // Kind of a literal that closes with the given state.
  function automatic logic [3:0] finish_kind(base_t b, logic bare_prefix, logic lwp,
                                             logic sp, logic se, logic [1:0] sm);
    logic [3:0] k;
    priority if (bare_prefix || lwp) begin
      k = KIND_ILLEGAL;
    end else if (sp || se) begin
      k = KIND_FLOAT;
    end else begin
      k = KIND_DEC_INT + (4'(b) * 4'd3) + 4'(sm);
    end
    return k;
  endfunction

endpackage

/* rtl/numeric_literal_scanner.sv */
// ----------------------------------------------------------------------------
// Numeric literal scanner
// Scans numeric literals byte by byte and gives one kind/length per literal.
// ----------------------------------------------------------------------------
// The scanner takes one byte transfer per clock cycle unless a stalled result
// holds it back, and gives one result transfer when a literal closes: on the
// byte that cannot extend it (that byte is dropped), on an end-of-input
// transfer, or on the first byte of the next literal. A transfer passes the
// input register and then the scanner state update into the result register;
// the state update takes one byte per cycle unless the result stalls.
// A stalled result holds the result register, and one more byte may wait in
// the input register.
`timescale 1ns / 1ps
`include "numeric_literal_scanner_defines.svh"

module numeric_literal_scanner
  import nls_pkg::*;
#(
  parameter int LENGTH_LIMIT = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_value
  input  logic [1:0] s_tuser,   // [0] first, [1] at_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] literal_length
  output logic [4:0] m_tuser    // [3:0] literal_kind, [4] length_saturated
);

  localparam int LenCap = (LENGTH_LIMIT < 255) ? LENGTH_LIMIT : 255;
  localparam logic [8:0] CapVal  = 9'(LenCap);
  localparam logic [8:0] CapPlus = 9'(LenCap + 1);

  // Saturating add to the consumed count.
  function automatic logic [8:0] take_bytes(logic [8:0] cnt, logic [1:0] n);
    logic [9:0] sum;
    sum = {1'b0, cnt} + {8'd0, n};
    if (sum > {1'b0, CapPlus}) begin
      return CapPlus;
    end
    return sum[8:0];
  endfunction

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;
  logic       in_end;

  // Scanner state.
  phase_t     phase, phase_next;
  base_t      base, base_next;
  logic       seen_point, seen_point_next;
  logic       seen_exp, seen_exp_next;
  logic       last_point, last_point_next;
  logic [1:0] suffix, suffix_next;
  logic [8:0] count, count_next;
  logic [1:0] pending, pending_next;

  // Result register.
  logic       res_valid;
  logic [3:0] res_kind;
  logic [7:0] res_len;
  logic       res_sat;

  logic       emit;
  logic [3:0] emit_kind;
  logic [8:0] emit_count;
  logic [7:0] len_next;
  logic       sat_next;
  logic       advance;
  logic       fire;
  logic       do_main;

  assign advance  = !res_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  assign m_tvalid = res_valid;
  assign m_tdata  = res_len;
  assign m_tuser  = {res_sat, res_kind};

  // Input register: holds one transfer while the result register is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser[0];
      in_end   <= s_tuser[1];
    end
  end

  // Next state of the scanner for the byte in the input register.
  always_comb begin
    phase_next      = phase;
    base_next       = base;
    seen_point_next = seen_point;
    seen_exp_next   = seen_exp;
    last_point_next = last_point;
    suffix_next     = suffix;
    count_next      = count;
    pending_next    = pending;
    emit            = 1'b0;
    emit_kind       = KIND_ILLEGAL;
    do_main         = 1'b0;

    if (in_end || in_first) begin
      // Close any open literal as at the end of input.
      unique case (phase)
        PH_IDLE: begin
        end
        PH_BAD: begin
          count_next = 9'd1;
          emit       = 1'b1;
          emit_kind  = KIND_ILLEGAL;
        end
        PH_POINT: begin
          count_next      = take_bytes(count_next, 2'd1);
          seen_point_next = 1'b1;
          last_point_next = 1'b1;
          emit            = 1'b1;
          emit_kind       = finish_kind(base_next,
                                        (base_next != BASE_DEC) && (count_next <= 9'd2),
                                        last_point_next, seen_point_next,
                                        seen_exp_next, suffix_next);
        end
        PH_ZERO, PH_MAIN, PH_EXP, PH_SUFFIX: begin
          emit      = 1'b1;
          emit_kind = finish_kind(base_next,
                                  (base_next != BASE_DEC) && (count_next <= 9'd2),
                                  last_point_next, seen_point_next,
                                  seen_exp_next, suffix_next);
        end
        default: begin
        end
      endcase
      if (emit) begin
        phase_next   = PH_IDLE;
        pending_next = 2'd0;
      end
      // The closing literal keeps its own length before a new one starts.
      emit_count = count_next;
      // Open a new literal with this byte.
      if (!in_end) begin
        base_next       = BASE_DEC;
        seen_point_next = 1'b0;
        seen_exp_next   = 1'b0;
        last_point_next = 1'b0;
        suffix_next     = SFX_NONE;
        pending_next    = 2'd0;
        count_next      = 9'd1;
        priority if (in_byte == CH_0) begin
          phase_next = PH_ZERO;
        end else if (is_dec_digit(in_byte)) begin
          phase_next = PH_MAIN;
        end else begin
          phase_next = PH_BAD;
        end
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
        end
        PH_ZERO: begin
          phase_next = PH_MAIN;
          priority if (in_byte == CH_LX || in_byte == CH_UX) begin
            base_next  = BASE_HEX;
            count_next = take_bytes(count_next, 2'd1);
          end else if (in_byte == CH_LB || in_byte == CH_UB) begin
            base_next  = BASE_BIN;
            count_next = take_bytes(count_next, 2'd1);
          end else if (in_byte == CH_LO || in_byte == CH_UO) begin
            base_next  = BASE_OCT;
            count_next = take_bytes(count_next, 2'd1);
          end else begin
            do_main = 1'b1;
          end
        end
        PH_MAIN: begin
          do_main = 1'b1;
        end
        PH_POINT: begin
          if (in_byte == CH_POINT) begin
            emit = 1'b1;
          end else begin
            count_next      = take_bytes(count_next, 2'd1);
            seen_point_next = 1'b1;
            last_point_next = 1'b1;
            pending_next    = 2'd0;
            phase_next      = PH_MAIN;
            do_main         = 1'b1;
          end
        end
        PH_EXP: begin
          priority if ((pending == 2'd1) && (in_byte == CH_PLUS || in_byte == CH_MINUS)) begin
            pending_next = 2'd2;
          end else if (is_dec_digit(in_byte)) begin
            count_next      = take_bytes(count_next, 2'(pending + 2'd1));
            pending_next    = 2'd0;
            seen_exp_next   = 1'b1;
            last_point_next = 1'b0;
            phase_next      = PH_MAIN;
          end else begin
            emit = 1'b1;
          end
        end
        PH_SUFFIX: begin
          if (in_byte == CH_LZ || in_byte == CH_UZ) begin
            count_next  = take_bytes(count_next, 2'd1);
            suffix_next = SFX_UZ;
          end
          emit = 1'b1;
        end
        PH_BAD: begin
          count_next = 9'd1;
          emit       = 1'b1;
        end
        default: begin
        end
      endcase

      // Byte handling shared by the digit phases.
      if (do_main) begin
        priority if ((base_next == BASE_DEC) && !seen_exp_next &&
                     (in_byte == CH_LE || in_byte == CH_UE)) begin
          phase_next   = PH_EXP;
          pending_next = 2'd1;
        end else if ((base_next == BASE_DEC) && (in_byte == CH_POINT)) begin
          if (seen_point_next) begin
            emit = 1'b1;
          end else begin
            phase_next   = PH_POINT;
            pending_next = 2'd1;
          end
        end else if (is_base_digit(base_next, in_byte)) begin
          count_next      = take_bytes(count_next, 2'd1);
          last_point_next = 1'b0;
        end else if (!((base_next != BASE_DEC) && (count_next <= 9'd2)) &&
                     !seen_point_next && !seen_exp_next &&
                     (in_byte == CH_LU || in_byte == CH_UU)) begin
          count_next      = take_bytes(count_next, 2'd1);
          last_point_next = 1'b0;
          suffix_next     = SFX_U;
          phase_next      = PH_SUFFIX;
        end else begin
          emit = 1'b1;
        end
      end

      // A closing literal returns to idle; its kind follows the final state.
      if (emit) begin
        if (phase != PH_BAD) begin
          emit_kind = finish_kind(base_next,
                                  (base_next != BASE_DEC) && (count_next <= 9'd2),
                                  last_point_next, seen_point_next,
                                  seen_exp_next, suffix_next);
        end
        phase_next   = PH_IDLE;
        pending_next = 2'd0;
      end
      emit_count = count_next;
    end
  end

  // Result fields from the count at the close.
  always_comb begin
    sat_next = emit_count > CapVal;
    len_next = sat_next ? CapVal[7:0] : emit_count[7:0];
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      base       <= BASE_DEC;
      seen_point <= 1'b0;
      seen_exp   <= 1'b0;
      last_point <= 1'b0;
      suffix     <= SFX_NONE;
      count      <= 9'd0;
      pending    <= 2'd0;
    end else if (fire) begin
      phase      <= phase_next;
      base       <= base_next;
      seen_point <= seen_point_next;
      seen_exp   <= seen_exp_next;
      last_point <= last_point_next;
      suffix     <= suffix_next;
      count      <= count_next;
      pending    <= pending_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid && emit;
    end
    if (fire && emit) begin
      res_kind <= emit_kind;
      res_len  <= len_next;
      res_sat  <= sat_next;
    end
  end

  // Input stalls only behind a full, stalled result register.
  `NLS_ASSERT(a_stall_cause, !s_tready |-> (in_valid && res_valid && !m_tready))
  // Reset leaves both registers empty.
  `NLS_ASSERT_ALWAYS(a_reset_empty, rst |=> (!res_valid && !in_valid))
  // A saturated length always reads as the cap.
  `NLS_ASSERT(a_sat_len, (res_valid && res_sat) |-> (res_len == CapVal[7:0]))
  // Bytes are held back only while waiting for lookahead.
  `NLS_ASSERT(a_pending_phase, (pending != 2'd0) |-> (phase == PH_POINT || phase == PH_EXP))
  // An open literal has consumed at least its first byte.
  `NLS_ASSERT(a_open_count, (phase != PH_IDLE) |-> (count != 9'd0))

endmodule
